@@ hdl/mmcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared types and constants for the min/max column decimator.
// ----------------------------------------------------------------------------
package mmcd_pkg;

	localparam int LEN_W        = 25;
	localparam int COL_W        = 12;
	localparam int POS_W        = 12;
	localparam int DIFF_W       = LEN_W + 1;
	localparam int SAT_W        = 29;
	localparam int CFG_DATA_W   = 25;
	localparam int CFG_INDEX_W  = 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;

	localparam int DEF_MAX_SAMPLES = 16777216;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam logic [LEN_W-1:0] SAMPLE_COUNT_RESET = LEN_W'(4096);
	localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = COL_W'(1024);
	localparam logic [COL_W-1:0] COLUMN_LIMIT       = COL_W'(2048);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SAMPLE_COUNT = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             is_raw;
		logic             fresh;
		logic             close;
		logic             last;
		logic [POS_W-1:0] position;
	} tag_t;

	localparam int TAG_W = $bits(tag_t);

endpackage
`default_nettype wire

@@ hdl/min_max_column_decimator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_column_decimator
// Reduces a window of audio samples to per-column min/max pairs for display.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid/sample_stall) takes one signed sample per
//   transfer. result channel (result_valid/result_stall) returns is_raw,
//   low_value, high_value, position and last.
//   Windows of at most twice column_count samples pass through raw, one
//   result per sample; longer windows give one min/max result per column,
//   with last set on the final column.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   sample_count (index 0) or column_count (index 1); values saturate and
//   every write restarts the window. Write only while the block is idle.
//   Each accepted sample is written into the queue; the result of a raw or
//   closing sample is loaded from the queue head into the output register
//   once the output is free. Throughput: one sample per cycle while sample_stall is low.
//   A four-entry queue holds samples that cannot yet reach the output while
//   result_stall is high; when it is full, sample_stall rises.
//   Reset: sample_count 4096, column_count 1024, queue and output empty.
// ----------------------------------------------------------------------------
module min_max_column_decimator
	import mmcd_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [CFG_INDEX_W-1:0]        cfg_index,
	input  wire  [CFG_DATA_W-1:0]         cfg_data,
	input  wire                           sample_valid,
	output logic                          sample_stall,
	input  wire  signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  wire                           result_stall,
	output logic                          is_raw,
	output logic signed [SAMPLE_BITS-1:0] low_value,
	output logic signed [SAMPLE_BITS-1:0] high_value,
	output logic [POS_W-1:0]              position,
	output logic                          last
);

	localparam int EntryW = TAG_W + SAMPLE_BITS;

	tag_t              front_tag;
	tag_t              head_tag;
	logic              accept;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [EntryW-1:0] head;

	assign cfg_ready    = 1'b1;
	assign sample_stall = q_full;
	assign accept       = sample_valid && !q_full;
	assign head_tag     = tag_t'(head[EntryW-1 -: TAG_W]);

	mmcd_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.tag      (front_tag)
	);

	mmcd_queue #(
		.DATA_W(EntryW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (sample_valid),
		.push_data({front_tag, sample}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head     (head)
	);

	mmcd_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_tag       (head_tag),
		.q_sample    (head[SAMPLE_BITS-1:0]),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_raw      (is_raw),
		.low_value   (low_value),
		.high_value  (high_value),
		.position    (position),
		.last        (last)
	);

endmodule
`default_nettype wire

@@ hdl/mmcd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmcd_front
// Holds the window registers and classifies each accepted sample: raw
// pass-through or column member, and whether it closes a column.
// ----------------------------------------------------------------------------
module mmcd_front
	import mmcd_pkg::*;
#(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	input  wire                    accept,
	output tag_t                   tag
);

	localparam logic [SAT_W-1:0] MaxSamplesW = SAT_W'(MAX_SAMPLES);

	logic [LEN_W-1:0]  len_q;
	logic [COL_W-1:0]  cols_q;
	logic [LEN_W-1:0]  si_q;
	logic [COL_W-1:0]  ci_q;
	logic [DIFF_W-1:0] d_q;
	logic              fresh_q;

	logic [LEN_W-1:0]  len_sat;
	logic [COL_W-1:0]  cols_sat;
	logic              start;
	logic              raw_mode;
	logic [LEN_W:0]    si_inc;
	logic              fin_raw;
	logic [DIFF_W-1:0] d_eff;
	logic [DIFF_W-1:0] dm;
	logic [DIFF_W-1:0] d_close;
	logic [COL_W-1:0]  ci_eff;
	logic [COL_W:0]    ci_inc;
	logic              fresh_eff;
	logic              close;
	logic              fin_dec;

	always_comb begin
		len_sat = cfg_data[LEN_W-1:0];
		if (len_sat == '0) begin
			len_sat = LEN_W'(1);
		end else if (SAT_W'(len_sat) > MaxSamplesW) begin
			len_sat = LEN_W'(MAX_SAMPLES);
		end
		cols_sat = cfg_data[COL_W-1:0];
		if (cols_sat == '0) begin
			cols_sat = COL_W'(1);
		end else if (cols_sat > COLUMN_LIMIT) begin
			cols_sat = COLUMN_LIMIT;
		end
	end

	always_comb begin
		start     = (si_q == '0);
		raw_mode  = (DIFF_W'(len_q) <= DIFF_W'({cols_q, 1'b0}));
		si_inc    = (LEN_W+1)'(si_q) + (LEN_W+1)'(1);
		fin_raw   = (si_inc >= (LEN_W+1)'(len_q));
		d_eff     = start ? DIFF_W'(len_q) : d_q;
		ci_eff    = start ? '0 : ci_q;
		fresh_eff = start ? 1'b1 : fresh_q;
		dm        = d_eff - DIFF_W'(cols_q);
		d_close   = dm + DIFF_W'(len_q);
		close     = (dm < DIFF_W'(cols_q));
		ci_inc    = (COL_W+1)'(ci_eff) + (COL_W+1)'(1);
		fin_dec   = close && (ci_inc >= (COL_W+1)'(cols_q));
	end

	always_comb begin
		if (raw_mode) begin
			tag.is_raw   = 1'b1;
			tag.fresh    = 1'b1;
			tag.close    = 1'b1;
			tag.last     = fin_raw;
			tag.position = si_q[POS_W-1:0];
		end else begin
			tag.is_raw   = 1'b0;
			tag.fresh    = fresh_eff;
			tag.close    = close;
			tag.last     = fin_dec;
			tag.position = POS_W'(ci_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= SAMPLE_COUNT_RESET;
			cols_q  <= COLUMN_COUNT_RESET;
			si_q    <= '0;
			ci_q    <= '0;
			d_q     <= '0;
			fresh_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_COUNT: len_q  <= len_sat;
				REG_COLUMN_COUNT: cols_q <= cols_sat;
				default:          len_q  <= len_q;
			endcase
			si_q    <= '0;
			fresh_q <= 1'b1;
		end else if (accept) begin
			if (raw_mode) begin
				si_q <= fin_raw ? '0 : si_inc[LEN_W-1:0];
			end else if (fin_dec) begin
				si_q    <= '0;
				fresh_q <= 1'b1;
			end else if (close) begin
				si_q    <= si_inc[LEN_W-1:0];
				ci_q    <= ci_inc[COL_W-1:0];
				d_q     <= d_close;
				fresh_q <= 1'b1;
			end else begin
				si_q    <= si_inc[LEN_W-1:0];
				ci_q    <= ci_eff;
				d_q     <= dm;
				fresh_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/mmcd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmcd_queue
// Short FIFO between the classifier and the min/max unit.
// ----------------------------------------------------------------------------
module mmcd_queue
	import mmcd_pkg::*;
#(
	parameter int DATA_W = TAG_W + DEF_SAMPLE_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wire  [DATA_W-1:0] push_data,
	output logic              full,
	input  wire               pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] head
);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/mmcd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmcd_back
// Tracks the running minimum and maximum of the open column and holds the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module mmcd_back
	import mmcd_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	input  tag_t                         q_tag,
	input  wire signed [SAMPLE_BITS-1:0] q_sample,
	output logic                         q_pop,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic                         is_raw,
	output logic signed [SAMPLE_BITS-1:0] low_value,
	output logic signed [SAMPLE_BITS-1:0] high_value,
	output logic [POS_W-1:0]             position,
	output logic                         last
);

	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] min_new;
	logic signed [SAMPLE_BITS-1:0] max_new;
	logic                          out_free;
	logic                          load;

	always_comb begin
		if (q_tag.fresh) begin
			min_new = q_sample;
			max_new = q_sample;
		end else begin
			min_new = (q_sample < min_q) ? q_sample : min_q;
			max_new = (q_sample > max_q) ? q_sample : max_q;
		end
	end

	assign out_free = !result_valid || !result_stall;
	assign q_pop    = q_valid && (!q_tag.close || out_free);
	assign load     = q_pop && q_tag.close;

	always_ff @(posedge clk) begin
		if (q_pop && !q_tag.is_raw) begin
			min_q <= min_new;
			max_q <= max_new;
		end
		if (load) begin
			is_raw     <= q_tag.is_raw;
			low_value  <= q_tag.is_raw ? q_sample : min_new;
			high_value <= q_tag.is_raw ? q_sample : max_new;
			position   <= q_tag.position;
			last       <= q_tag.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ hdl/mmcd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmcd_checker
// Port-level checks on the min/max column decimator, bound to the top level.
// ----------------------------------------------------------------------------
module mmcd_checker
	import mmcd_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          sample_stall,
	input wire                          result_valid,
	input wire                          result_stall,
	input wire                          is_raw,
	input wire signed [SAMPLE_BITS-1:0] low_value,
	input wire signed [SAMPLE_BITS-1:0] high_value,
	input wire [POS_W-1:0]              position,
	input wire                          last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(low_value)
			&& $stable(high_value) && $stable(position) && $stable(last)
			&& $stable(is_raw))
		else $error("stalled result changed");

	a_raw_equal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_raw |-> low_value == high_value)
		else $error("raw result with differing low and high");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_raw |-> low_value <= high_value)
		else $error("column minimum above maximum");

	a_full_drains: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall && !result_valid |=> !sample_stall)
		else $error("full queue held with a free output");

endmodule

bind min_max_column_decimator mmcd_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_mmcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.is_raw      (is_raw),
	.low_value   (low_value),
	.high_value  (high_value),
	.position    (position),
	.last        (last)
);
`default_nettype wire

@@ tb/tb_min_max_column_decimator.sv @@
// ----------------------------------------------------------------------------
// tb_min_max_column_decimator
// Self-checking bench for the min/max column decimator. A scoreboard class
// keeps its own copy of the window counters and column bounds, predicts the
// raw or min/max result of every accepted sample and checks each result
// transfer in order. Directed corners come first, then randomized phases that
// reprogram the window length and column count while the block is idle. The
// sender works in random bursts and the receiver stalls on a shifting pattern.
// ----------------------------------------------------------------------------
module tb_min_max_column_decimator
	import mmcd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SMP_W          = DEF_SAMPLE_BITS;
	localparam int          CYCLE_LIMIT    = 1000000;
	localparam int          SETTLE_CYCLES  = 10;
	localparam int          RANDOM_ITEMS   = 1550;
	localparam int          MAX_PRINTED    = 60;
	localparam logic [24:0] LEN_MAX        = 25'(DEF_MAX_SAMPLES);

	typedef struct packed {
		logic                    is_raw;
		logic signed [SMP_W-1:0] low_value;
		logic signed [SMP_W-1:0] high_value;
		logic [POS_W-1:0]        position;
		logic                    last;
	} column_result_t;

	class decimator_scoreboard;
		bit [LEN_W-1:0]          len;
		bit [COL_W-1:0]          cols;
		bit [LEN_W-1:0]          sample_idx;
		bit [COL_W-1:0]          column_idx;
		bit [35:0]               sample_prod;
		bit [35:0]               column_prod;
		logic signed [SMP_W-1:0] col_min;
		logic signed [SMP_W-1:0] col_max;
		bit                      fresh;
		column_result_t          expected_q[$];
		int                      errors;

		function new();
			len = SAMPLE_COUNT_RESET;
			cols = COLUMN_COUNT_RESET;
			col_min = '0;
			col_max = '0;
			errors = 0;
			restart_window();
		endfunction

		function void restart_window();
			sample_idx = '0;
			column_idx = '0;
			sample_prod = '0;
			column_prod = '0;
			fresh = 1'b1;
		endfunction

		task report(input string msg);
			if (errors < MAX_PRINTED)
				$display("[%0t] %s", $realtime, msg);
			errors++;
		endtask

		function void write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
			bit [LEN_W-1:0] len_v;
			bit [COL_W-1:0] col_v;
			if (idx == REG_SAMPLE_COUNT) begin
				len_v = data[LEN_W-1:0];
				if (len_v == 0)
					len_v = LEN_W'(1);
				if (len_v > LEN_MAX)
					len_v = LEN_MAX;
				len = len_v;
			end else begin
				col_v = data[COL_W-1:0];
				if (col_v == 0)
					col_v = COL_W'(1);
				if (col_v > COLUMN_LIMIT)
					col_v = COLUMN_LIMIT;
				cols = col_v;
			end
			restart_window();
		endfunction

		function void note_sample(input logic signed [SMP_W-1:0] s);
			column_result_t r;
			bit [25:0]      twice;
			bit             fin;
			if (sample_idx == 0) begin
				sample_prod = '0;
				column_prod = 36'(len);
				column_idx = '0;
				fresh = 1'b1;
			end
			twice = {13'b0, cols, 1'b0};
			if (26'(len) <= twice) begin
				fin = (26'(sample_idx) + 26'd1 >= 26'(len));
				r.is_raw = 1'b1;
				r.low_value = s;
				r.high_value = s;
				r.position = sample_idx[POS_W-1:0];
				r.last = fin;
				expected_q.push_back(r);
				if (fin)
					restart_window();
				else
					sample_idx++;
				return;
			end
			if (fresh) begin
				col_min = s;
				col_max = s;
				fresh = 1'b0;
			end else begin
				if (s < col_min)
					col_min = s;
				if (s > col_max)
					col_max = s;
			end
			sample_prod += 36'(cols);
			if (37'(sample_prod) + 37'(cols) > 37'(column_prod)) begin
				fin = (13'(column_idx) + 13'd1 >= 13'(cols));
				r.is_raw = 1'b0;
				r.low_value = col_min;
				r.high_value = col_max;
				r.position = column_idx;
				r.last = fin;
				expected_q.push_back(r);
				if (fin) begin
					restart_window();
				end else begin
					column_idx++;
					column_prod += 36'(len);
					fresh = 1'b1;
					sample_idx++;
				end
			end else begin
				sample_idx++;
			end
		endfunction

		task check_result(input column_result_t got);
			column_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none expected: raw=%0b lo=%0d hi=%0d pos=%0d last=%0b",
					got.is_raw, got.low_value, got.high_value, got.position, got.last));
				return;
			end
			exp = expected_q.pop_front();
			if (got.is_raw !== exp.is_raw)
				report($sformatf("is_raw: got %0b exp %0b", got.is_raw, exp.is_raw));
			if (got.low_value !== exp.low_value)
				report($sformatf("low_value: got %0d exp %0d", got.low_value, exp.low_value));
			if (got.high_value !== exp.high_value)
				report($sformatf("high_value: got %0d exp %0d", got.high_value, exp.high_value));
			if (got.position !== exp.position)
				report($sformatf("position: got %0d exp %0d", got.position, exp.position));
			if (got.last !== exp.last)
				report($sformatf("last: got %0b exp %0b", got.last, exp.last));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic                    is_raw;
	logic signed [SMP_W-1:0] low_value;
	logic signed [SMP_W-1:0] high_value;
	logic [POS_W-1:0]        position;
	logic                    last;

	decimator_scoreboard sb = new();
	int                  cycle_count = 0;
	int                  burst_left = 0;

	min_max_column_decimator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_raw      (is_raw),
		.low_value   (low_value),
		.high_value  (high_value),
		.position    (position),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// receiver stall pattern: free, light, heavy or periodic, switching at random
	initial begin
		int stall_mode;
		int stall_left;
		stall_mode = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(32, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= ((cycle_count % 11) < 5);
			endcase
		end
	end

	always @(posedge clk) begin
		column_result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.is_raw = is_raw;
			got.low_value = low_value;
			got.high_value = high_value;
			got.position = position;
			got.last = last;
			sb.check_result(got);
		end
	end

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			1: return SMP_W'(int'($urandom_range(0, 15)) - 8);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_sample(input logic signed [SMP_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(s);
		burst_left--;
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		logic signed [SMP_W-1:0] corner[8];
		logic [CFG_DATA_W-1:0]   data;
		int unsigned             cols_now;
		int unsigned             twice;
		int unsigned             len_now;
		int                      n;
		int                      w;
		int                      random_items;

		corner = '{24'sh800000, 24'sh7fffff, 24'sh000000, 24'shffffff,
			24'sh000001, 24'sh555555, 24'shaaaaaa, 24'sh7fffff};
		random_items = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: columns of four samples
		foreach (corner[i])
			push_sample(corner[i]);
		settle();

		// zero writes saturate to one: single-sample raw windows
		cfg_write(REG_COLUMN_COUNT, '0);
		cfg_write(REG_SAMPLE_COUNT, '0);
		push_sample(24'sh7fffff);
		push_sample(24'sh800000);
		settle();

		// raw/min-max boundary
		cfg_write(REG_COLUMN_COUNT, CFG_DATA_W'(2));
		cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(4));
		repeat (4)
			push_sample(pick_sample());
		settle();
		cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(5));
		repeat (5)
			push_sample(pick_sample());
		settle();

		// upper saturation on both registers
		cfg_write(REG_COLUMN_COUNT, CFG_DATA_W'(4095));
		cfg_write(REG_SAMPLE_COUNT, 25'h1ffffff);
		repeat (3)
			push_sample(pick_sample());
		settle();

		while (random_items < RANDOM_ITEMS) begin
			w = $urandom_range(0, 5);
			if (w == 1 || w >= 3) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: data = CFG_DATA_W'($urandom_range(1, 12));
					6: data = CFG_DATA_W'($urandom_range(13, 300));
					7: data = CFG_DATA_W'(2048);
					8: data = CFG_DATA_W'($urandom_range(0, 4095));
					default: data = CFG_DATA_W'($urandom);
				endcase
				cfg_write(REG_COLUMN_COUNT, data);
			end
			if (w >= 2) begin
				cols_now = 32'(sb.cols);
				twice = 2 * cols_now;
				case ($urandom_range(0, 9))
					0, 1, 2: data = CFG_DATA_W'($urandom_range(1, (twice < 64) ? twice : 64));
					3, 4, 5, 6: data = CFG_DATA_W'(twice + $urandom_range(1, cols_now * 6 + 1));
					7: data = CFG_DATA_W'(twice + $urandom_range(0, 1));
					8: data = CFG_DATA_W'($urandom);
					default: data = $urandom_range(0, 1) ? '0
						: CFG_DATA_W'(32'(LEN_MAX) + $urandom_range(0, 2));
				endcase
				cfg_write(REG_SAMPLE_COUNT, data);
			end
			len_now = 32'(sb.len);
			if (w == 0)
				n = $urandom_range(1, 60);
			else if (len_now <= 160)
				n = len_now * $urandom_range(1, 3)
					+ ($urandom_range(0, 1) ? $urandom_range(0, len_now - 1) : 0);
			else
				n = $urandom_range(1, 160);
			if (n > 200)
				n = 200;
			repeat (n)
				push_sample(pick_sample());
			random_items += n;
			settle();
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/mmcd_pkg.sv
hdl/mmcd_front.sv
hdl/mmcd_queue.sv
hdl/mmcd_back.sv
hdl/min_max_column_decimator.sv
hdl/mmcd_checker.sv
tb/tb_min_max_column_decimator.sv
